FILE: rtl/core/conv2d_gradient_engine_unit_defines.svh
// ----------------------------------------------------------------------------
// conv2d_gradient_engine_unit_defines
// Assertion helpers for the convolution gradient engine.
// ----------------------------------------------------------------------------
// Each macro checks a property on the rising clock, idle while reset is high.
`ifndef CONV2D_GRADIENT_ENGINE_UNIT_DEFINES_SVH
`define CONV2D_GRADIENT_ENGINE_UNIT_DEFINES_SVH

// Plain clocked property with a message on failure.
`define CGE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication that must hold in the cycle after the trigger.
`define CGE_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

FILE: rtl/core/cge_pkg.sv
// ----------------------------------------------------------------------------
// cge_pkg
// Shared types, sizes and helpers of the convolution gradient engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cge_pkg;

   // Matrix and kernel limits.
   localparam int MaxDim    = 32;
   localparam int MaxKernel = 8;
   localparam int DataW     = 16;
   localparam int ResW      = 48;
   localparam int IdxW      = 5;
   localparam int KIdxW     = 3;
   localparam int DimAddrW  = 2 * IdxW;
   localparam int KerAddrW  = 2 * KIdxW;

   // Command codes of an input item.
   typedef enum logic [2:0] {
      CMD_LOAD_IN   = 3'd0,
      CMD_LOAD_W    = 3'd1,
      CMD_LOAD_G    = 3'd2,
      CMD_COMP_IN   = 3'd3,
      CMD_COMP_W    = 3'd4,
      CMD_READ      = 3'd5
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_STRIDE_H  = 3'd0,
      REG_STRIDE_W  = 3'd1,
      REG_IN_ROWS   = 3'd2,
      REG_IN_COLS   = 3'd3,
      REG_W_ROWS    = 3'd4,
      REG_W_COLS    = 3'd5,
      REG_G_ROWS    = 3'd6,
      REG_G_COLS    = 3'd7
   } reg_idx_type;

   // Saturate a matrix dimension into 1..MaxDim.
   function automatic logic [5:0] sat_dim(input logic [5:0] v);
      logic [5:0] r;
      r = v;
      if (v == 6'd0) r = 6'd1;
      else if (v > 6'(MaxDim)) r = 6'(MaxDim);
      return r;
   endfunction

   // Saturate a kernel dimension into 1..MaxKernel.
   function automatic logic [3:0] sat_kern(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      if (v == 4'd0) r = 4'd1;
      else if (v > 4'(MaxKernel)) r = 4'(MaxKernel);
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/conv2d_gradient_engine_unit.sv
// ----------------------------------------------------------------------------
// conv2d_gradient_engine_unit
// 2D convolution backward engine: input gradient and weight gradient.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on req_* (cmd in tuser, row, col and value in tdata) and each
//   gives one item on rsp_* (result in tdata, error and done flags in tuser).
//   Registers are to be written on csr_* only while the block is idle; the
//   block itself does not enforce this, and csr_ready is always high.
//   Loads and errors answer in the cycle after acceptance; a result read
//   answers after a RAM read, through the S_RDATA state.
//   A compute clears the 1024-entry result RAM, then runs
//   grad_rows*grad_cols*w_rows*w_cols multiply-accumulate steps on the one
//   shared multiplier, each step reading operands, multiplying, then adding
//   and writing back. The block takes no item during that time.
//   After reset the result RAM is cleared before the first item is taken;
//   configuration writes are taken throughout.
//   A result held on rsp_* waits for rsp_tready; a new item is taken in the
//   cycle it drains, so a stalled receiver stalls the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_gradient_engine_unit
   import cge_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input items.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // row[4:0], col[9:5], value[25:10], zero pad
   input  wire logic [2:0]  req_tuser,   // cmd[2:0]
   // Result items.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // result_value[47:0]
   output logic [1:0]       rsp_tuser,   // error[0], done_res[1]
   // Register writes.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [5:0]  csr_data
);

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_RDATA = 7'b0000100,
      S_CLEAR = 7'b0001000,
      S_ISSUE = 7'b0010000,
      S_MUL   = 7'b0100000,
      S_ACC   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [5:0] stride_h_ff, stride_w_ff, in_rows_ff, in_cols_ff, g_rows_ff, g_cols_ff;
   logic [3:0] w_rows_ff, w_cols_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_h_ff <= 6'd1;
         stride_w_ff <= 6'd1;
         in_rows_ff  <= 6'd32;
         in_cols_ff  <= 6'd32;
         w_rows_ff   <= 4'd2;
         w_cols_ff   <= 4'd2;
         g_rows_ff   <= 6'd1;
         g_cols_ff   <= 6'd1;
      end else if (csr_valid) begin
         case (reg_idx_type'(csr_index))
            REG_STRIDE_H: stride_h_ff <= csr_data;
            REG_STRIDE_W: stride_w_ff <= csr_data;
            REG_IN_ROWS:  in_rows_ff  <= csr_data;
            REG_IN_COLS:  in_cols_ff  <= csr_data;
            REG_W_ROWS:   w_rows_ff   <= csr_data[3:0];
            REG_W_COLS:   w_cols_ff   <= csr_data[3:0];
            REG_G_ROWS:   g_rows_ff   <= csr_data;
            REG_G_COLS:   g_cols_ff   <= csr_data;
            default:      g_cols_ff   <= g_cols_ff;
         endcase
      end
   end

   // Dimensions in use.
   logic [5:0] ir, ic, gr, gc;
   logic [3:0] wr, wc;
   assign ir = sat_dim(in_rows_ff);
   assign ic = sat_dim(in_cols_ff);
   assign gr = sat_dim(g_rows_ff);
   assign gc = sat_dim(g_cols_ff);
   assign wr = sat_kern(w_rows_ff);
   assign wc = sat_kern(w_cols_ff);

   // Input item fields.
   logic        [IdxW-1:0]  req_row, req_col;
   logic signed [DataW-1:0] req_value;
   cmd_type                 req_cmd;
   logic                    accept;
   assign req_row   = req_tdata[4:0];
   assign req_col   = req_tdata[9:5];
   assign req_value = req_tdata[25:10];
   assign req_cmd   = cmd_type'(req_tuser);
   assign accept    = req_tvalid && req_tready;

   // Window check: the last kernel placement must fit inside the input.
   // The span is formed at full 12-bit width so large strides cannot wrap.
   logic [11:0] span_h, span_w;
   logic        win_err;
   assign span_h  = (12'(gr) - 12'd1) * 12'(stride_h_ff) + 12'(wr);
   assign span_w  = (12'(gc) - 12'd1) * 12'(stride_w_ff) + 12'(wc);
   assign win_err = (span_h > 12'(ir)) || (span_w > 12'(ic));

   // Load bound checks.
   logic ld_in_ok, ld_w_ok, ld_g_ok;
   assign ld_in_ok = ({1'b0, req_row} < ir) && ({1'b0, req_col} < ic);
   assign ld_w_ok  = ({4'd0, req_row} < {5'd0, wr}) && ({4'd0, req_col} < {5'd0, wc});
   assign ld_g_ok  = ({1'b0, req_row} < gr) && ({1'b0, req_col} < gc);

   // Loop counters of the compute sequence.
   logic [IdxW-1:0]  i_ff, j_ff, rb_ff, cb_ff, i_in, j_in, rb_in, cb_in;
   logic [KIdxW-1:0] a_ff, b_ff, a_in, b_in;
   logic [DimAddrW-1:0] clr_ff, clr_in;
   logic wmode_ff, wmode_in;
   logic last_b, last_a, last_j, last_i;
   assign last_b = ({1'b0, b_ff} == wc - 4'd1);
   assign last_a = ({1'b0, a_ff} == wr - 4'd1);
   assign last_j = ({1'b0, j_ff} == gc - 6'd1);
   assign last_i = ({1'b0, i_ff} == gr - 6'd1);

   // Addresses of the current step.
   logic [IdxW-1:0]     in_r, in_c;
   logic [DimAddrW-1:0] in_addr, g_addr, dest_addr;
   logic [KerAddrW-1:0] w_addr;
   assign in_r      = rb_ff + IdxW'(a_ff);
   assign in_c      = cb_ff + IdxW'(b_ff);
   assign in_addr   = {in_r, in_c};
   assign g_addr    = {i_ff, j_ff};
   assign w_addr    = {a_ff, b_ff};
   assign dest_addr = wmode_ff ? {IdxW'(a_ff), IdxW'(b_ff)} : in_addr;

   // Memories.
   logic                    issue;
   logic [DataW-1:0]        in_rd, w_rd, g_rd;
   logic [ResW-1:0]         res_rd, mac_sum;
   logic                    res_we, res_re;
   logic [DimAddrW-1:0]     res_waddr, res_raddr;
   logic [ResW-1:0]         res_wdata;
   assign issue = (state_ff == S_ISSUE);

   cge_ram #(.WIDTH(DataW), .DEPTH(MaxDim * MaxDim)) u_in_ram (
      .clock   (clock),
      .wr_en   (accept && req_cmd == CMD_LOAD_IN && ld_in_ok),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (in_addr),
      .rd_data (in_rd)
   );

   cge_ram #(.WIDTH(DataW), .DEPTH(MaxKernel * MaxKernel)) u_w_ram (
      .clock   (clock),
      .wr_en   (accept && req_cmd == CMD_LOAD_W && ld_w_ok),
      .wr_addr ({req_row[KIdxW-1:0], req_col[KIdxW-1:0]}),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (w_addr),
      .rd_data (w_rd)
   );

   cge_ram #(.WIDTH(DataW), .DEPTH(MaxDim * MaxDim)) u_g_ram (
      .clock   (clock),
      .wr_en   (accept && req_cmd == CMD_LOAD_G && ld_g_ok),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_value),
      .rd_en   (issue),
      .rd_addr (g_addr),
      .rd_data (g_rd)
   );

   // Result RAM: cleared in the sweep states, written back in the add step.
   assign res_we    = (state_ff == S_INIT) || (state_ff == S_CLEAR) || (state_ff == S_ACC);
   assign res_waddr = (state_ff == S_ACC) ? dest_addr : clr_ff;
   assign res_wdata = (state_ff == S_ACC) ? mac_sum : '0;
   assign res_re    = issue || (accept && req_cmd == CMD_READ);
   assign res_raddr = issue ? dest_addr : {req_row, req_col};

   cge_ram #(.WIDTH(ResW), .DEPTH(MaxDim * MaxDim)) u_res_ram (
      .clock   (clock),
      .wr_en   (res_we),
      .wr_addr (res_waddr),
      .wr_data (res_wdata),
      .rd_en   (res_re),
      .rd_addr (res_raddr),
      .rd_data (res_rd)
   );

   // Operand is a kernel weight for the input gradient, an input element otherwise.
   cge_mac u_mac (
      .clock  (clock),
      .mul_en (state_ff == S_MUL),
      .op_a   (g_rd),
      .op_b   (wmode_ff ? in_rd : w_rd),
      .acc_in (res_rd),
      .sum    (mac_sum)
   );

   // Response register.
   logic            rsp_valid_ff, rsp_valid_in, rsp_err_ff, rsp_err_in;
   logic [ResW-1:0] rsp_value_ff, rsp_value_in;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_err_in   = rsp_err_ff;
      rsp_value_in = rsp_value_ff;
      clr_in       = clr_ff;
      wmode_in     = wmode_ff;
      i_in  = i_ff;
      j_in  = j_ff;
      a_in  = a_ff;
      b_in  = b_ff;
      rb_in = rb_ff;
      cb_in = cb_ff;
      case (state_ff)
         S_INIT: begin
            clr_in = clr_ff + DimAddrW'(1);
            if (&clr_ff) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               rsp_value_in = '0;
               rsp_err_in   = 1'b0;
               rsp_valid_in = 1'b1;
               case (req_cmd)
                  CMD_LOAD_IN: rsp_err_in = !ld_in_ok;
                  CMD_LOAD_W:  rsp_err_in = !ld_w_ok;
                  CMD_LOAD_G:  rsp_err_in = !ld_g_ok;
                  CMD_COMP_IN, CMD_COMP_W: begin
                     if (win_err) begin
                        rsp_err_in = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b0;
                        wmode_in     = (req_cmd == CMD_COMP_W);
                        clr_in       = '0;
                        i_in  = '0;
                        j_in  = '0;
                        a_in  = '0;
                        b_in  = '0;
                        rb_in = '0;
                        cb_in = '0;
                        state_in     = S_CLEAR;
                     end
                  end
                  CMD_READ: begin
                     rsp_valid_in = 1'b0;
                     state_in     = S_RDATA;
                  end
                  default: rsp_err_in = 1'b1;
               endcase
            end
         end
         S_RDATA: begin
            rsp_value_in = res_rd;
            rsp_err_in   = 1'b0;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_CLEAR: begin
            clr_in = clr_ff + DimAddrW'(1);
            if (&clr_ff) state_in = S_ISSUE;
         end
         S_ISSUE: state_in = S_MUL;
         S_MUL:   state_in = S_ACC;
         S_ACC: begin
            state_in = S_ISSUE;
            if (!last_b) begin
               b_in = b_ff + KIdxW'(1);
            end else begin
               b_in = '0;
               if (!last_a) begin
                  a_in = a_ff + KIdxW'(1);
               end else begin
                  a_in = '0;
                  if (!last_j) begin
                     j_in  = j_ff + IdxW'(1);
                     cb_in = cb_ff + stride_w_ff[IdxW-1:0];
                  end else begin
                     j_in  = '0;
                     cb_in = '0;
                     if (!last_i) begin
                        i_in  = i_ff + IdxW'(1);
                        rb_in = rb_ff + stride_h_ff[IdxW-1:0];
                     end else begin
                        rsp_value_in = '0;
                        rsp_err_in   = 1'b0;
                        rsp_valid_in = 1'b1;
                        state_in     = S_IDLE;
                     end
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
      end
   end

   // Payload and counter registers.
   always_ff @(posedge clock) begin
      rsp_err_ff   <= rsp_err_in;
      rsp_value_ff <= rsp_value_in;
      wmode_ff     <= wmode_in;
      i_ff  <= i_in;
      j_ff  <= j_in;
      a_ff  <= a_in;
      b_ff  <= b_in;
      rb_ff <= rb_in;
      cb_ff <= cb_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {!rsp_err_ff, rsp_err_ff};

`include "conv2d_gradient_engine_unit_defines.svh"

   // Items are taken only when the sequencer is idle.
   `CGE_ASSERT(a_ready_idle, !req_tready || state_ff == S_IDLE, "ready outside idle")
   // A refused item never carries a result value.
   `CGE_ASSERT(a_err_zero, !(rsp_valid_ff && rsp_err_ff) || rsp_value_ff == '0, "error with data")
   // A result read moves to its data cycle right after acceptance.
   `CGE_ASSERT_NEXT(a_read_resp, accept && req_cmd == CMD_READ, state_ff == S_RDATA,
                    "read data cycle missing")
   // The compute steps always follow the issue, multiply, add order.
   `CGE_ASSERT_NEXT(a_mac_order, state_ff == S_MUL, state_ff == S_ACC, "mac order broken")

endmodule

`default_nettype wire

FILE: rtl/core/cge_ram.sv
// ----------------------------------------------------------------------------
// cge_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cge_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, and read data registered; it holds while no read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/cge_mac.sv
// ----------------------------------------------------------------------------
// cge_mac
// Shared multiply-accumulate unit: registered product, then a 48-bit add.
// ----------------------------------------------------------------------------
`default_nettype none

module cge_mac
   import cge_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     mul_en,
   input  wire logic signed [DataW-1:0]  op_a,
   input  wire logic signed [DataW-1:0]  op_b,
   input  wire logic        [ResW-1:0]   acc_in,
   output logic             [ResW-1:0]   sum
);

   logic signed [2*DataW-1:0] prod_ff;
   logic signed [2*DataW-1:0] prod_in;

   // Product stage.
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Accumulate stage, wrapping modulo 2^48.
   assign sum = acc_in + ResW'(prod_ff);

endmodule

`default_nettype wire
